@@ sv/rfe_pkg.sv @@
`default_nettype none

package rfe_pkg;

    // Default sizes; the first two are handed to the top level as parameter defaults.
    localparam int unsigned MAX_DIMENSION_DEF = 4096;
    localparam int unsigned ADDRESS_BITS_DEF  = 48;
    localparam int unsigned QUEUE_DEPTH       = 4;

    // Fixed field widths.
    localparam int unsigned DIM_W   = 13;
    localparam int unsigned POS_W   = 12;
    localparam int unsigned PITCH_W = 16;
    localparam int unsigned PB_W    = 3;
    localparam int unsigned COLOR_W = 32;
    localparam int unsigned FILL_W  = 24;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CFG_IDX_W = 3;

    // Command codes on the input channel.
    localparam logic [1:0] ACT_FILL  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_PUT   = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_READY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = 3'd5;

    // Register reset values.
    localparam logic [DIM_W-1:0]   RST_SCREEN_WIDTH  = 13'd1024;
    localparam logic [DIM_W-1:0]   RST_SCREEN_HEIGHT = 13'd768;
    localparam logic [PITCH_W-1:0] RST_ROW_PITCH     = 16'd4096;
    localparam logic [PB_W-1:0]    RST_PIXEL_BYTES   = 3'd4;

    // Classified item kinds, as carried through the queue.
    typedef enum logic [KIND_W-1:0] {
        K_NONE,
        K_START,
        K_PUT,
        K_TICK
    } t_kind;

    // Screen geometry shared by the front and back parts.
    typedef struct packed {
        logic               display_ready;
        logic [DIM_W-1:0]   screen_width;
        logic [DIM_W-1:0]   screen_height;
        logic [PITCH_W-1:0] row_pitch;
        logic [PB_W-1:0]    pixel_bytes;
    } t_geom;

endpackage

`default_nettype wire

@@ sv/rfe_if.sv @@
`default_nettype none

interface rfe_cmd_if;
    import rfe_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [DIM_W-1:0]   rect_width;
    logic [DIM_W-1:0]   rect_height;
    logic [COLOR_W-1:0] fill_color;

    modport source (output valid, action, pos_x, pos_y, rect_width, rect_height,
                    fill_color, input ready);
    modport sink   (input valid, action, pos_x, pos_y, rect_width, rect_height,
                    fill_color, output ready);
endinterface

interface rfe_pix_if #(
    parameter int unsigned ADDRESS_BITS = rfe_pkg::ADDRESS_BITS_DEF
);
    import rfe_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    write_valid;
    logic [ADDRESS_BITS-1:0] write_address;
    logic [COLOR_W-1:0]      write_data;
    logic                    write_wide;
    logic                    last_pixel;
    logic                    engine_busy;

    modport source (output valid, write_valid, write_address, write_data, write_wide,
                    last_pixel, engine_busy, input ready);
    modport sink   (input valid, write_valid, write_address, write_data, write_wide,
                    last_pixel, engine_busy, output ready);
endinterface

interface rfe_cfg_if #(
    parameter int unsigned ADDRESS_BITS = rfe_pkg::ADDRESS_BITS_DEF
);
    import rfe_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_W-1:0]    index;
    logic [ADDRESS_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/rfe_queue.sv @@
`default_nettype none

module rfe_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? bump(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? bump(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

@@ sv/rfe_front.sv @@
`default_nettype none

module rfe_front #(
    parameter int unsigned MAX_DIMENSION = rfe_pkg::MAX_DIMENSION_DEF,
    parameter int unsigned ADDRESS_BITS  = rfe_pkg::ADDRESS_BITS_DEF,
    parameter int unsigned ENTRY_W       = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    rfe_cmd_if.sink                      i_cmd,
    input  wire rfe_pkg::t_geom          i_geom,
    input  wire logic [ADDRESS_BITS-1:0] i_base,
    output logic                         o_push,
    output logic [ENTRY_W-1:0]           o_entry,
    input  wire logic                    i_full
);
    import rfe_pkg::*;

    localparam int unsigned PY_W = POS_W + PITCH_W;
    localparam int unsigned PX_W = POS_W + PB_W;

    logic               r_valid;
    t_kind              r_kind;
    logic [DIM_W-1:0]   r_cw;
    logic [DIM_W-1:0]   r_ch;
    logic [COLOR_W-1:0] r_color;
    logic [PY_W-1:0]    r_prod_y;
    logic [PX_W-1:0]    r_prod_x;

    t_kind              kind;
    logic [DIM_W-1:0]   sw, sh, room_x, room_y, want_w, want_h, cw, ch;
    logic [POS_W-1:0]   x, y;
    logic               in_range;
    logic               take;
    logic [ADDRESS_BITS-1:0] addr;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (32'(v) > MAX_DIMENSION) begin
            return DIM_W'(MAX_DIMENSION);
        end
        return v;
    endfunction

    // Classify the command and clip the rectangle against the screen.
    always_comb begin
        sw = clamp_dim(i_geom.screen_width);
        sh = clamp_dim(i_geom.screen_height);
        x  = (i_cmd.action == ACT_CLEAR) ? '0 : i_cmd.pos_x;
        y  = (i_cmd.action == ACT_CLEAR) ? '0 : i_cmd.pos_y;
        want_w = (i_cmd.action == ACT_CLEAR) ? sw : i_cmd.rect_width;
        want_h = (i_cmd.action == ACT_CLEAR) ? sh : i_cmd.rect_height;
        in_range = ({1'b0, x} < sw) && ({1'b0, y} < sh);
        room_x = sw - {1'b0, x};
        room_y = sh - {1'b0, y};
        cw = (want_w > room_x) ? room_x : want_w;
        ch = (want_h > room_y) ? room_y : want_h;
        unique case (i_cmd.action)
            ACT_FILL, ACT_CLEAR: begin
                kind = (i_geom.display_ready && in_range && cw != '0 && ch != '0)
                     ? K_START : K_NONE;
            end
            ACT_PUT: begin
                kind = i_geom.display_ready ? K_PUT : K_NONE;
            end
            default: begin
                kind = K_TICK;
            end
        endcase
    end

    assign o_push      = r_valid && !i_full;
    assign i_cmd.ready = !r_valid || !i_full;
    assign take        = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind   <= kind;
            r_cw     <= cw;
            r_ch     <= ch;
            r_color  <= i_cmd.fill_color;
            r_prod_y <= PY_W'(y) * PY_W'(i_geom.row_pitch);
            r_prod_x <= PX_W'(x) * PX_W'(i_geom.pixel_bytes);
        end
    end

    assign addr    = i_base + ADDRESS_BITS'(r_prod_y) + ADDRESS_BITS'(r_prod_x);
    assign o_entry = {r_kind, addr, r_cw, r_ch, r_color};

endmodule

`default_nettype wire

@@ sv/rfe_back.sv @@
`default_nettype none

module rfe_back #(
    parameter int unsigned ADDRESS_BITS = rfe_pkg::ADDRESS_BITS_DEF,
    parameter int unsigned ENTRY_W      = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [ENTRY_W-1:0] i_entry,
    output logic                    o_pop,
    input  wire rfe_pkg::t_geom     i_geom,
    rfe_pix_if.source               o_pix
);
    import rfe_pkg::*;

    t_kind                   e_kind;
    logic [ADDRESS_BITS-1:0] e_addr;
    logic [DIM_W-1:0]        e_cw, e_ch;
    logic [COLOR_W-1:0]      e_color;

    logic                    r_filling, n_filling;
    logic [DIM_W-1:0]        r_col, n_col, r_row, n_row;
    logic [DIM_W-1:0]        r_cw, n_cw, r_ch, n_ch;
    logic [ADDRESS_BITS-1:0] r_row_addr, n_row_addr;
    logic [FILL_W-1:0]       r_color, n_color;

    logic                    r_out_valid;
    logic                    res_wv, res_wide, res_last;
    logic [ADDRESS_BITS-1:0] res_addr;
    logic [COLOR_W-1:0]      res_data;
    logic [DIM_W:0]          col_inc, row_inc;
    logic [ADDRESS_BITS-1:0] next_row_addr;
    logic [DIM_W+PB_W-1:0]   col_off;

    assign {e_kind, e_addr, e_cw, e_ch, e_color} = i_entry;
    assign o_pop = i_valid && (!r_out_valid || o_pix.ready);

    always_comb begin
        n_filling  = r_filling;
        n_col      = r_col;
        n_row      = r_row;
        n_cw       = r_cw;
        n_ch       = r_ch;
        n_row_addr = r_row_addr;
        n_color    = r_color;
        res_wv     = 1'b0;
        res_addr   = '0;
        res_data   = '0;
        res_wide   = 1'b0;
        res_last   = 1'b0;
        col_inc    = {1'b0, r_col} + (DIM_W+1)'(1);
        row_inc    = {1'b0, r_row} + (DIM_W+1)'(1);
        next_row_addr = r_row_addr + ADDRESS_BITS'(i_geom.row_pitch);
        // The column offset follows the current pixel size on every tick.
        col_off    = (DIM_W+PB_W)'(r_col) * (DIM_W+PB_W)'(i_geom.pixel_bytes);
        unique case (e_kind)
            K_START: begin
                if (!r_filling) begin
                    n_filling  = 1'b1;
                    n_col      = '0;
                    n_row      = '0;
                    n_cw       = e_cw;
                    n_ch       = e_ch;
                    n_row_addr = e_addr;
                    n_color    = e_color[FILL_W-1:0];
                end
            end
            K_PUT: begin
                res_wv   = 1'b1;
                res_addr = e_addr;
                res_data = e_color;
                res_wide = 1'b1;
            end
            K_TICK: begin
                if (r_filling) begin
                    res_wv   = 1'b1;
                    res_addr = r_row_addr + ADDRESS_BITS'(col_off);
                    res_data = COLOR_W'(r_color);
                    if (col_inc >= {1'b0, r_cw}) begin
                        // End of a row: step down one pitch.
                        n_col      = '0;
                        n_row_addr = next_row_addr;
                        if (row_inc >= {1'b0, r_ch}) begin
                            n_row     = '0;
                            n_filling = 1'b0;
                            res_last  = 1'b1;
                        end else begin
                            n_row = row_inc[DIM_W-1:0];
                        end
                    end else begin
                        n_col      = col_inc[DIM_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filling   <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_filling <= n_filling;
                r_col     <= n_col;
                r_row     <= n_row;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cw                <= n_cw;
            r_ch                <= n_ch;
            r_row_addr          <= n_row_addr;
            r_color             <= n_color;
            o_pix.write_valid   <= res_wv;
            o_pix.write_address <= res_addr;
            o_pix.write_data    <= res_data;
            o_pix.write_wide    <= res_wide;
            o_pix.last_pixel    <= res_last;
            o_pix.engine_busy   <= n_filling;
        end
    end

    assign o_pix.valid = r_out_valid;

endmodule

`default_nettype wire

@@ sv/rectangle_fill_engine_unit.sv @@
// Channel   Dir  Handshake          Beat carries
// i_cmd     in   valid / ready      action, pos_x, pos_y, rect_width, rect_height, fill_color
// i_cfg     in   valid / ready      register index, write data
// o_pix     out  valid / ready      write_valid, write_address, write_data, write_wide,
//                                   last_pixel, engine_busy
//
// Every command beat yields exactly one result beat, in order, one per cycle sustained
// while o_pix is ready. A beat passes the front register (clip and address products), the
// queue write and the back output register; ticks step the back part's fill counters.
// Reset (i_rst_n low at a clock edge) empties the pipeline, stops any fill and loads
// the configuration defaults. A stalled o_pix holds its beat while the front keeps
// taking commands until the queue is full.
`default_nettype none

module rectangle_fill_engine_unit #(
    parameter int unsigned MAX_DIMENSION = rfe_pkg::MAX_DIMENSION_DEF,
    parameter int unsigned ADDRESS_BITS  = rfe_pkg::ADDRESS_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rfe_cmd_if.sink   i_cmd,
    rfe_cfg_if.sink   i_cfg,
    rfe_pix_if.source o_pix
);
    import rfe_pkg::*;

    // A queue entry holds the kind, the precomputed byte address, the clipped
    // size and the full color word.
    localparam int unsigned ENTRY_W = KIND_W + ADDRESS_BITS + 2 * DIM_W + COLOR_W;

    t_geom                   r_geom;
    logic [ADDRESS_BITS-1:0] r_base;

    logic                    q_push, q_full, q_pop, q_valid;
    logic [ENTRY_W-1:0]      q_in, q_out;

    // Configuration registers. Writes always complete; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.display_ready <= 1'b0;
            r_geom.screen_width  <= RST_SCREEN_WIDTH;
            r_geom.screen_height <= RST_SCREEN_HEIGHT;
            r_geom.row_pitch     <= RST_ROW_PITCH;
            r_geom.pixel_bytes   <= RST_PIXEL_BYTES;
            r_base               <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DISPLAY_READY: r_geom.display_ready <= i_cfg.data[0];
                CFG_SCREEN_WIDTH:  r_geom.screen_width  <= i_cfg.data[DIM_W-1:0];
                CFG_SCREEN_HEIGHT: r_geom.screen_height <= i_cfg.data[DIM_W-1:0];
                CFG_ROW_PITCH:     r_geom.row_pitch     <= i_cfg.data[PITCH_W-1:0];
                CFG_PIXEL_BYTES:   r_geom.pixel_bytes   <= i_cfg.data[PB_W-1:0];
                CFG_BASE_ADDRESS:  r_base               <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Front: takes commands, clips rectangles and forms start addresses.
    rfe_front #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .ADDRESS_BITS  (ADDRESS_BITS),
        .ENTRY_W       (ENTRY_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_geom  (r_geom),
        .i_base  (r_base),
        .o_push  (q_push),
        .o_entry (q_in),
        .i_full  (q_full)
    );

    // Short queue so the front keeps accepting while the output stalls.
    rfe_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // Back: owns the fill state and produces one pixel write per tick while filling, and per put.
    rfe_back #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .ENTRY_W      (ENTRY_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (q_out),
        .o_pop   (q_pop),
        .i_geom  (r_geom),
        .o_pix   (o_pix)
    );

endmodule

`default_nettype wire
